// File: hw/rtl/e2bcd_pkg.sv
package e2bcd_pkg;

  localparam int unsigned EpochW = 32;

  // Days: epoch / 86400 = (epoch >> 7) / 675, estimated by a reciprocal and corrected once.
  localparam int unsigned DayShift   = 35;
  localparam logic [25:0] DayRecip   = 26'd50903316;
  localparam logic [9:0]  DayDivLow  = 10'd675;

  // Reciprocal constants, exact over the value ranges they see.
  localparam int unsigned Div60Shift  = 23;
  localparam logic [17:0] Recip60     = 18'd139811;
  localparam int unsigned Div7Shift   = 19;
  localparam logic [16:0] Recip7      = 17'd74899;
  localparam int unsigned Div365Shift = 24;
  localparam logic [15:0] Recip365    = 16'd45965;
  localparam int unsigned Div153Shift = 20;
  localparam logic [12:0] Recip153    = 13'd6854;

  localparam logic [5:0]  SecsPerMin  = 6'd60;
  localparam logic [2:0]  DaysPerWeek = 3'd7;
  localparam logic [2:0]  ThursdayOff = 3'd4;

  // The day count is shifted to March-based eras; 1970 falls in era 4, 2000 opens era 5.
  localparam logic [17:0] DoeOffset   = 18'd135080;
  localparam logic [17:0] EraDays     = 18'd146097;
  localparam logic [17:0] CentDays    = 18'd36524;
  localparam logic [8:0]  YearDays    = 9'd365;
  localparam logic [11:0] Era4Year    = 12'd1600;
  localparam logic [11:0] Era5Year    = 12'd2000;
  localparam logic [11:0] YearLow     = 12'd2000;
  localparam logic [11:0] YearHigh    = 12'd2099;
  localparam logic [11:0] YearBase    = 12'd1900;
  localparam logic [3:0]  MonthJan    = 4'd10;

  // First day of each March-based month within the year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Two BCD digits of a value below 100.
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

// File: hw/rtl/epoch_to_bcd_datetime.sv
// Throughput: one epoch word per cycle; busy stays low, a ten-stage pipeline of
// reciprocal multipliers holds up to ten words in flight.
// valid_o is high for exactly one cycle per word; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears the valid bits, so words in flight are dropped.
module epoch_to_bcd_datetime (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [e2bcd_pkg::EpochW-1:0]     epoch_seconds_i,
  output logic                             valid_o,
  output logic [6:0]                       sec_bcd_o,
  output logic [6:0]                       min_bcd_o,
  output logic [5:0]                       hour_bcd_o,
  output logic [2:0]                       weekday_bcd_o,
  output logic [5:0]                       date_bcd_o,
  output logic [4:0]                       month_bcd_o,
  output logic [7:0]                       year_bcd_o,
  output logic                             year_out_of_range_o
);
  import e2bcd_pkg::*;

  localparam int unsigned Stages = 10;

  typedef struct packed {
    logic [5:0] ss;
    logic [5:0] mm;
    logic [4:0] hrs;
    logic [2:0] wd;
  } clock_t;

  typedef struct packed {
    logic [24:0] xh;
    logic [6:0]  low7;
    logic [15:0] qa;
  } s1_t;

  typedef struct packed {
    logic [10:0] r;
    logic [15:0] qa;
    logic [6:0]  low7;
  } s2_t;

  typedef struct packed {
    logic [15:0] days;
    logic [16:0] rem;
  } s3_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [10:0] mt;
    logic [17:0] doe;
    logic        era5;
    logic [16:0] w1;
    logic [12:0] q7;
  } s4_t;

  typedef struct packed {
    logic [5:0]  ss;
    logic [10:0] mt;
    logic [4:0]  hrs;
    logic [2:0]  wd;
    logic [17:0] doe;
    logic [17:0] n;
    logic        era5;
  } s5_t;

  typedef struct packed {
    clock_t      clk;
    logic [17:0] doe;
    logic [8:0]  yoe;
    logic        era5;
  } s6_t;

  typedef struct packed {
    clock_t     clk;
    logic [8:0] doy;
    logic [8:0] yoe;
    logic       era5;
  } s7_t;

  typedef struct packed {
    clock_t     clk;
    logic [8:0] doy;
    logic [3:0] mp;
    logic [8:0] yoe;
    logic       era5;
  } s8_t;

  typedef struct packed {
    clock_t     clk;
    logic [4:0] day;
    logic [3:0] mon;
    logic [6:0] yy;
    logic       oor;
  } s9_t;

  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] mins;
    logic [5:0] hour;
    logic [2:0] wday;
    logic [5:0] date;
    logic [4:0] month;
    logic [7:0] year;
    logic       oor;
  } s10_t;

  logic [Stages-1:0] vld_q, vld_d;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;
  s5_t  s5_q, s5_d;
  s6_t  s6_q, s6_d;
  s7_t  s7_q, s7_d;
  s8_t  s8_q, s8_d;
  s9_t  s9_q, s9_d;
  s10_t s10_q, s10_d;

  // Every stage advances each cycle, so a word is never refused.
  assign busy  = 1'b0;
  assign vld_d = {vld_q[Stages-2:0], start & ~busy};

  // Stage 1: day estimate from the upper 25 bits.
  logic [50:0] day_prod;
  always_comb begin
    day_prod   = 51'(epoch_seconds_i[31:7]) * 51'(DayRecip);
    s1_d.xh    = epoch_seconds_i[31:7];
    s1_d.low7  = epoch_seconds_i[6:0];
    s1_d.qa    = day_prod[50:DayShift];
  end

  // Stage 2: remainder of the estimate, below twice the divisor.
  logic [25:0] back_prod;
  always_comb begin
    back_prod = 26'(s1_q.qa) * 26'(DayDivLow);
    s2_d.r    = 11'(26'(s1_q.xh) - back_prod);
    s2_d.qa   = s1_q.qa;
    s2_d.low7 = s1_q.low7;
  end

  // Stage 3: one correction step gives whole days and seconds of the day.
  logic       r_ge;
  logic [10:0] r_fix;
  always_comb begin
    r_ge      = s2_q.r >= 11'(DayDivLow);
    r_fix     = r_ge ? s2_q.r - 11'(DayDivLow) : s2_q.r;
    s3_d.days = s2_q.qa + 16'(r_ge);
    s3_d.rem  = {r_fix[9:0], s2_q.low7};
  end

  // Stage 4: minutes of the day, day of era, and the weekday quotient.
  logic [34:0] mt_prod;
  logic [17:0] shifted;
  logic [33:0] q7_prod;
  always_comb begin
    mt_prod   = 35'(s3_q.rem) * 35'(Recip60);
    shifted   = 18'(s3_q.days) + DoeOffset;
    q7_prod   = 34'(s3_q.days + 16'(ThursdayOff)) * 34'(Recip7);
    s4_d.rem  = s3_q.rem;
    s4_d.mt   = mt_prod[33:Div60Shift];
    s4_d.era5 = shifted >= EraDays;
    s4_d.doe  = (shifted >= EraDays) ? shifted - EraDays : shifted;
    s4_d.w1   = 17'(s3_q.days) + 17'(ThursdayOff);
    s4_d.q7   = q7_prod[31:Div7Shift];
  end

  // Stage 5: seconds, hours, weekday, and the leap-corrected day count of the era.
  logic [28:0] hr_prod;
  logic [31:0] q1460_prod;
  logic [2:0]  cent_cnt;
  logic        era_last;
  logic [16:0] wd_rem;
  always_comb begin
    hr_prod    = 29'(s4_q.mt) * 29'(Recip60);
    q1460_prod = 32'(s4_q.doe[17:2]) * 32'(Recip365);
    cent_cnt   = 3'(s4_q.doe >= CentDays) + 3'(s4_q.doe >= 18'd73048)
               + 3'(s4_q.doe >= 18'd109572) + 3'(s4_q.doe >= EraDays - 18'd1);
    era_last   = s4_q.doe == EraDays - 18'd1;
    wd_rem     = s4_q.w1 - 17'(s4_q.q7) * 17'(DaysPerWeek);
    s5_d.ss    = 6'(s4_q.rem - 17'(s4_q.mt) * 17'(SecsPerMin));
    s5_d.mt    = s4_q.mt;
    s5_d.hrs   = hr_prod[27:Div60Shift];
    s5_d.wd    = wd_rem[2:0] + 3'd1;
    s5_d.doe   = s4_q.doe;
    s5_d.n     = s4_q.doe - 18'(q1460_prod[31:Div365Shift]) + 18'(cent_cnt)
               - 18'(era_last);
    s5_d.era5  = s4_q.era5;
  end

  // Stage 6: minutes and year of era.
  logic [33:0] yoe_prod;
  always_comb begin
    yoe_prod     = 34'(s5_q.n) * 34'(Recip365);
    s6_d.clk.ss  = s5_q.ss;
    s6_d.clk.mm  = 6'(s5_q.mt - 11'(s5_q.hrs) * 11'(SecsPerMin));
    s6_d.clk.hrs = s5_q.hrs;
    s6_d.clk.wd  = s5_q.wd;
    s6_d.doe     = s5_q.doe;
    s6_d.yoe     = yoe_prod[32:Div365Shift];
    s6_d.era5    = s5_q.era5;
  end

  // Stage 7: day of the March-based year.
  logic [1:0]  c100;
  logic [17:0] year_base;
  logic [17:0] doy_full;
  always_comb begin
    c100      = 2'(s6_q.yoe >= 9'd100) + 2'(s6_q.yoe >= 9'd200) + 2'(s6_q.yoe >= 9'd300);
    year_base = 18'(s6_q.yoe) * 18'(YearDays) + 18'(s6_q.yoe[8:2]) - 18'(c100);
    doy_full  = s6_q.doe - year_base;
    s7_d.clk  = s6_q.clk;
    s7_d.doy  = doy_full[8:0];
    s7_d.yoe  = s6_q.yoe;
    s7_d.era5 = s6_q.era5;
  end

  // Stage 8: March-based month index.
  logic [11:0] mp_arg;
  logic [24:0] mp_prod;
  always_comb begin
    mp_arg    = 12'(s7_q.doy) * 12'd5 + 12'd2;
    mp_prod   = 25'(mp_arg) * 25'(Recip153);
    s8_d.clk  = s7_q.clk;
    s8_d.doy  = s7_q.doy;
    s8_d.mp   = mp_prod[23:Div153Shift];
    s8_d.yoe  = s7_q.yoe;
    s8_d.era5 = s7_q.era5;
  end

  // Stage 9: civil day, month, full year and its last two decimal digits.
  logic [8:0]  day_full;
  logic        jan_feb;
  logic [11:0] year_full;
  logic [11:0] y_rel;
  always_comb begin
    day_full  = s8_q.doy - month_start(s8_q.mp) + 9'd1;
    jan_feb   = s8_q.mp >= MonthJan;
    year_full = 12'(s8_q.yoe) + (s8_q.era5 ? Era5Year : Era4Year) + 12'(jan_feb);
    y_rel     = year_full - YearBase;
    s9_d.clk  = s8_q.clk;
    s9_d.day  = day_full[4:0];
    s9_d.mon  = jan_feb ? s8_q.mp - 4'd9 : s8_q.mp + 4'd3;
    s9_d.oor  = (year_full < YearLow) || (year_full > YearHigh);
    priority if (y_rel >= 12'd200) begin
      s9_d.yy = 7'(y_rel - 12'd200);
    end else if (y_rel >= 12'd100) begin
      s9_d.yy = 7'(y_rel - 12'd100);
    end else begin
      s9_d.yy = 7'(y_rel);
    end
  end

  // Stage 10: BCD packing into the output register.
  logic [7:0] sec_b, min_b, hour_b, date_b, month_b;
  always_comb begin
    sec_b       = bcd2(7'(s9_q.clk.ss));
    min_b       = bcd2(7'(s9_q.clk.mm));
    hour_b      = bcd2(7'(s9_q.clk.hrs));
    date_b      = bcd2(7'(s9_q.day));
    month_b     = bcd2(7'(s9_q.mon));
    s10_d.sec   = sec_b[6:0];
    s10_d.mins  = min_b[6:0];
    s10_d.hour  = hour_b[5:0];
    s10_d.wday  = s9_q.clk.wd;
    s10_d.date  = date_b[5:0];
    s10_d.month = month_b[4:0];
    s10_d.year  = bcd2(s9_q.yy);
    s10_d.oor   = s9_q.oor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    s4_q  <= s4_d;
    s5_q  <= s5_d;
    s6_q  <= s6_d;
    s7_q  <= s7_d;
    s8_q  <= s8_d;
    s9_q  <= s9_d;
    s10_q <= s10_d;
  end

  assign valid_o             = vld_q[Stages-1];
  assign sec_bcd_o           = s10_q.sec;
  assign min_bcd_o           = s10_q.mins;
  assign hour_bcd_o          = s10_q.hour;
  assign weekday_bcd_o       = s10_q.wday;
  assign date_bcd_o          = s10_q.date;
  assign month_bcd_o         = s10_q.month;
  assign year_bcd_o          = s10_q.year;
  assign year_out_of_range_o = s10_q.oor;

endmodule

// File: hw/rtl/e2bcd_chk.sv
module e2bcd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [6:0]  sec_bcd_o,
  input logic [6:0]  min_bcd_o,
  input logic [5:0]  hour_bcd_o,
  input logic [2:0]  weekday_bcd_o,
  input logic [5:0]  date_bcd_o,
  input logic [4:0]  month_bcd_o,
  input logic [7:0]  year_bcd_o,
  input logic        year_out_of_range_o
);

  // Every accepted word comes out on valid_o after passing through every pipeline stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##10 valid_o)
    else $error("accepted word did not come out after ten cycles");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 10))
    else $error("result word without a matching accepted word");

  a_time_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (sec_bcd_o[3:0] <= 4'd9 && sec_bcd_o[6:4] <= 3'd5 &&
                 min_bcd_o[3:0] <= 4'd9 && min_bcd_o[6:4] <= 3'd5 &&
                 hour_bcd_o[3:0] <= 4'd9 &&
                 (hour_bcd_o[5:4] <= 2'd1 || hour_bcd_o[3:0] <= 4'd3)))
    else $error("time fields are not legal BCD");

  a_date_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (weekday_bcd_o != 3'd0 && date_bcd_o != 6'd0 &&
                 date_bcd_o[3:0] <= 4'd9 && month_bcd_o != 5'd0 &&
                 month_bcd_o[3:0] <= 4'd9 && month_bcd_o <= 5'h12 &&
                 year_bcd_o[3:0] <= 4'd9 && year_bcd_o[7:4] <= 4'd9))
    else $error("date fields are not legal BCD");

endmodule

bind epoch_to_bcd_datetime e2bcd_chk u_e2bcd_chk (.*);
